/* hdl/etf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the escape-time fractal pixel engine.
// Depends on nothing; every other file imports it.
package etf_pkg;

    localparam int FRAC_BITS = 56;
    localparam int SCREEN_W  = 1200;
    localparam int SCREEN_H  = 800;

    localparam logic [2:0] REG_KIND      = 3'd0;
    localparam logic [2:0] REG_ITER_LOG2 = 3'd1;
    localparam logic [2:0] REG_CENTER_RE = 3'd2;
    localparam logic [2:0] REG_CENTER_IM = 3'd3;
    localparam logic [2:0] REG_STEP      = 3'd4;
    localparam logic [2:0] REG_JULIA_RE  = 3'd5;
    localparam logic [2:0] REG_JULIA_IM  = 3'd6;

    localparam logic [1:0] KIND_JULIA = 2'd1;
    localparam logic [1:0] KIND_SHIP  = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [9:0]  pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [10:0] iteration_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } result_t;

    typedef struct packed {
        logic [1:0]         fractal_kind;
        logic [3:0]         max_iter_log2;
        logic signed [63:0] center_re;
        logic signed [63:0] center_im;
        logic [62:0]        pixel_step;
        logic signed [63:0] julia_re;
        logic signed [63:0] julia_im;
    } cfg_t;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } point_t;

    localparam logic [7:0] COS_HALF [0:128] = '{
        8'd255,8'd254,8'd254,8'd254,8'd254,8'd254,8'd253,8'd253,
        8'd252,8'd251,8'd251,8'd250,8'd249,8'd248,8'd247,8'd246,
        8'd245,8'd244,8'd242,8'd241,8'd239,8'd238,8'd236,8'd235,
        8'd233,8'd231,8'd229,8'd228,8'd226,8'd224,8'd221,8'd219,
        8'd217,8'd215,8'd213,8'd210,8'd208,8'd205,8'd203,8'd200,
        8'd198,8'd195,8'd193,8'd190,8'd187,8'd184,8'd182,8'd179,
        8'd176,8'd173,8'd170,8'd167,8'd164,8'd161,8'd158,8'd155,
        8'd152,8'd149,8'd146,8'd143,8'd139,8'd136,8'd133,8'd130,
        8'd127,8'd124,8'd121,8'd118,8'd115,8'd111,8'd108,8'd105,
        8'd102,8'd99, 8'd96, 8'd93, 8'd90, 8'd87, 8'd84, 8'd81,
        8'd78, 8'd75, 8'd72, 8'd70, 8'd67, 8'd64, 8'd61, 8'd59,
        8'd56, 8'd54, 8'd51, 8'd49, 8'd46, 8'd44, 8'd41, 8'd39,
        8'd37, 8'd35, 8'd33, 8'd30, 8'd28, 8'd26, 8'd25, 8'd23,
        8'd21, 8'd19, 8'd18, 8'd16, 8'd15, 8'd13, 8'd12, 8'd10,
        8'd9,  8'd8,  8'd7,  8'd6,  8'd5,  8'd4,  8'd3,  8'd3,
        8'd2,  8'd1,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0
    };

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
            begin
                sat_add = s[64] ? S64_MIN : S64_MAX;
            end
            else
            begin
                sat_add = s[63:0];
            end
        end
    endfunction

    function automatic logic signed [63:0] with_sign(input logic neg, input logic [63:0] m);
        begin
            if (neg)
            begin
                with_sign = m[63] ? S64_MIN : -$signed(m);
            end
            else
            begin
                with_sign = m[63] ? S64_MAX : $signed(m);
            end
        end
    endfunction

    function automatic logic [7:0] palette_at(input logic [7:0] idx);
        logic [7:0] k;
        begin
            k = (idx > 8'd128) ? 8'(9'd256 - {1'b0, idx}) : idx;
            palette_at = COS_HALF[k];
        end
    endfunction

endpackage

/* hdl/etf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts pixel beats and maps them to points of the complex plane.
// Depends on etf_pkg; feeds etf_queue.
module etf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  etf_pkg::pixel_t pixel,
    input  etf_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output etf_pkg::point_t q_data
);
    import etf_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [74:0] prod_x_reg, prod_y_reg;
    logic        neg_x_reg, neg_y_reg;
    logic signed [12:0] off_x, off_y;
    logic [11:0] mag_x, mag_y;
    logic        accept;

    function automatic logic [63:0] half_cap(input logic [74:0] p, input logic neg);
        logic [73:0] q;
        begin
            q = p[74:1] + {73'd0, neg & p[0]};
            if ((|q[73:64]) || (q[63] && (|q[62:0])))
            begin
                half_cap = {1'b1, 63'd0};
            end
            else
            begin
                half_cap = q[63:0];
            end
        end
    endfunction

    assign busy   = s1_valid_reg | q_full;
    assign accept = start & ~busy;

    assign off_x = $signed({1'b0, pixel.pixel_x, 1'b0}) - 13'(SCREEN_W);
    assign off_y = $signed({2'b0, pixel.pixel_y, 1'b0}) - 13'(SCREEN_H);
    assign mag_x = off_x[12] ? 12'(-off_x) : off_x[11:0];
    assign mag_y = off_y[12] ? 12'(-off_y) : off_y[11:0];

    assign s1_valid_next = accept ? 1'b1 : 1'b0;
    assign q_push        = s1_valid_reg;

    always_comb
    begin
        q_data.re = sat_add(cfg.center_re, with_sign(neg_x_reg, half_cap(prod_x_reg, neg_x_reg)));
        q_data.im = sat_add(cfg.center_im, with_sign(neg_y_reg, half_cap(prod_y_reg, neg_y_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_x_reg <= {63'd0, mag_x} * {12'd0, cfg.pixel_step};
            prod_y_reg <= {63'd0, mag_y} * {12'd0, cfg.pixel_step};
            neg_x_reg  <= off_x[12];
            neg_y_reg  <= off_y[12];
        end
    end

endmodule

/* hdl/etf_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of mapped points between the front end and the iteration engine.
// Depends on etf_pkg.
module etf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  etf_pkg::point_t wr_data,
    input  logic            pop,
    output etf_pkg::point_t rd_data,
    output logic            full,
    output logic            empty
);
    import etf_pkg::*;

    point_t     mem [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/etf_mul.sv */
`timescale 1ns / 1ps
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier that forms the four partial products in turn.
// Depends on etf_pkg.
module etf_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] product
);
    import etf_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   k_reg;
    logic         run_reg, done_reg;
    logic [31:0]  ah, bh;
    logic [63:0]  pp;

    assign ah = k_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign bh = k_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp = {32'd0, ah} * {32'd0, bh};

    always_comb
    begin
        unique case (k_reg)
            2'd0:    acc_next = acc_reg + {64'd0, pp};
            2'd3:    acc_next = acc_reg + {pp, 64'd0};
            default: acc_next = acc_reg + {32'd0, pp, 32'd0};
        endcase
    end

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 2'd0;
        end
        else
        begin
            done_reg <= run_reg && (k_reg == 2'd3);
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= 2'd0;
            end
            else if (run_reg)
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* hdl/etf_back.sv */
`timescale 1ns / 1ps
// Iteration engine: runs the escape-time recurrence on queued points and builds the palette.
// Depends on etf_pkg, etf_mul; pulls from etf_queue.
module etf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  etf_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  etf_pkg::point_t  q_data,
    output logic             q_pop,
    output logic             done,
    output etf_pkg::result_t result
);
    import etf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic signed [63:0] zx_reg, zx_next, zy_reg, zy_next, cx_reg, cx_next, cy_reg, cy_next;
    logic [10:0] count_reg, count_next;
    logic        done_reg;
    result_t     result_reg, result_next;
    logic        mul_go;
    logic        done_xx, done_yy, done_xy;
    logic [127:0] acc_xx, acc_yy, acc_xy;
    logic [3:0]  lg;
    logic [10:0] limit;
    logic [62:0] sx, sy;
    logic [63:0] esc_sum;
    logic        neg_xy;
    logic [72:0] q_xy;
    logic [63:0] m_xy;
    logic signed [63:0] twoxy, diff;
    logic [20:0] phase_full;
    logic [7:0]  phase;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        begin
            mag = v[63] ? 64'(-v) : v;
        end
    endfunction

    function automatic logic [62:0] square_of(input logic [127:0] p);
        begin
            if ((|p[127:119]) || (p[118] && (|p[117:56])))
            begin
                square_of = {1'b1, 62'd0};
            end
            else
            begin
                square_of = p[118:56];
            end
        end
    endfunction

    always_comb
    begin
        if (cfg.max_iter_log2 < 4'd6)
        begin
            lg = 4'd6;
        end
        else if (cfg.max_iter_log2 > 4'd10)
        begin
            lg = 4'd10;
        end
        else
        begin
            lg = cfg.max_iter_log2;
        end
    end
    assign limit = 11'd1 << lg;

    assign sx      = square_of(acc_xx);
    assign sy      = square_of(acc_yy);
    assign esc_sum = {1'b0, sx} + {1'b0, sy};
    assign diff    = $signed({1'b0, sx}) - $signed({1'b0, sy});
    assign neg_xy  = (cfg.fractal_kind != KIND_SHIP) && (zx_reg[63] != zy_reg[63]);
    assign q_xy    = acc_xy[127:55] + {72'd0, neg_xy & (|acc_xy[54:0])};
    assign m_xy    = ((|q_xy[72:64]) || (q_xy[63] && (|q_xy[62:0]))) ? {1'b1, 63'd0}
                                                                        : q_xy[63:0];
    assign twoxy   = with_sign(neg_xy, m_xy);

    assign phase_full = ({10'd0, count_reg} * 21'd768) >> lg;
    assign phase      = phase_full[7:0];

    always_comb
    begin
        state_next  = state_reg;
        zx_next     = zx_reg;
        zy_next     = zy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        count_next  = count_reg;
        q_pop       = 1'b0;
        mul_go      = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    mul_go     = 1'b1;
                    count_next = 11'd0;
                    state_next = S_WAIT;
                    if (cfg.fractal_kind == KIND_JULIA)
                    begin
                        zx_next = q_data.re;
                        zy_next = q_data.im;
                        cx_next = cfg.julia_re;
                        cy_next = cfg.julia_im;
                    end
                    else
                    begin
                        zx_next = '0;
                        zy_next = '0;
                        cx_next = q_data.re;
                        cy_next = q_data.im;
                    end
                end
            end
            S_WAIT:
            begin
                if (done_xx)
                begin
                    if (esc_sum > (64'd1 << (FRAC_BITS + 2)))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        zy_next    = sat_add(twoxy, cy_reg);
                        zx_next    = sat_add(diff, cx_reg);
                        count_next = count_reg + 11'd1;
                        if (count_next == limit)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mul_go = 1'b1;
                        end
                    end
                end
            end
            S_OUT:
            begin
                state_next                  = S_IDLE;
                result_next.iteration_count = count_reg;
                if (count_reg == limit)
                begin
                    result_next.red   = 8'd0;
                    result_next.green = 8'd0;
                    result_next.blue  = 8'd0;
                end
                else
                begin
                    result_next.red   = palette_at(phase);
                    result_next.green = palette_at(phase + 8'd84);
                    result_next.blue  = palette_at(phase + 8'd172);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    etf_mul u_mul_xx (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go),
        .a       (mag(zx_next)),
        .b       (mag(zx_next)),
        .done    (done_xx),
        .product (acc_xx)
    );

    etf_mul u_mul_yy (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go),
        .a       (mag(zy_next)),
        .b       (mag(zy_next)),
        .done    (done_yy),
        .product (acc_yy)
    );

    etf_mul u_mul_xy (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go),
        .a       (mag(zx_next)),
        .b       (mag(zy_next)),
        .done    (done_xy),
        .product (acc_xy)
    );

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT) && done_yy == done_xy;
        end
    end

    always_ff @(posedge clk)
    begin
        zx_reg     <= zx_next;
        zy_reg     <= zy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

endmodule

/* hdl/escape_time_fractal_pixel.sv */
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel engine: configuration registers and wiring.
// Depends on etf_pkg, etf_front, etf_queue, etf_back.
//
// A pixel beat is taken when start is high and busy is low. Busy is high for the cycle after
// each beat while the point is mapped, and whenever the two-entry queue is full, so at most
// two pixels wait beside the one being iterated. The iteration engine, when idle, pops a
// queued point once the queue's count register shows it. Each escape-time iteration then
// loads the multipliers, which build the 64 x 64 products from 32 x 32 partial products in
// turn. A pixel leaves the engine once its point escapes or its iteration count reaches the
// limit. The result register then loads, and done is high for exactly one cycle while the
// new result is on result; it cannot be held off.
// Write configuration only while idle.
module escape_time_fractal_pixel (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  etf_pkg::pixel_t  pixel,
    output logic             done,
    output etf_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import etf_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push, q_pop, q_full, q_empty;
    point_t q_wr, q_rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fractal_kind  <= 2'd0;
            cfg_reg.max_iter_log2 <= 4'd8;
            cfg_reg.center_re     <= -64'sd36028797018963968;
            cfg_reg.center_im     <= 64'sd0;
            cfg_reg.pixel_step    <= 63'd288230376151712;
            cfg_reg.julia_re      <= -64'sd50440315826549555;
            cfg_reg.julia_im      <= 64'sd19466359029346232;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KIND:      cfg_reg.fractal_kind  <= cfg_data[1:0];
                REG_ITER_LOG2: cfg_reg.max_iter_log2 <= cfg_data[3:0];
                REG_CENTER_RE: cfg_reg.center_re     <= cfg_data;
                REG_CENTER_IM: cfg_reg.center_im     <= cfg_data;
                REG_STEP:      cfg_reg.pixel_step    <= cfg_data[62:0];
                REG_JULIA_RE:  cfg_reg.julia_re      <= cfg_data;
                REG_JULIA_IM:  cfg_reg.julia_im      <= cfg_data;
                default:       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    etf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr)
    );

    etf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    etf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rd),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule
